[sv/ilp_pkg.sv]
// Integer literal parser: shared codes, character constants and types.
// No dependencies; compiled first.
package ilp_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CH_W            = 8;
  localparam int unsigned OUT_VALUE_W     = 32;

  // parse phase
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  // radix codes, also the radix field of a result
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  // control part of the token state
  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] radix_sel;
    logic       negative;
    logic       failed;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{
    phase:     PH_START,
    radix_sel: RADIX_DEC,
    negative:  1'b0,
    failed:    1'b0
  };

  typedef struct packed {
    logic                          status;
    logic signed [OUT_VALUE_W-1:0] value;
    logic [1:0]                    radix;
  } res_t;

endpackage

[sv/ilp_in_if.sv]
// Character channel into the parser: valid/ready plus one character.
// Depends on ilp_pkg for the character width.
interface ilp_in_if;
  logic                      valid;
  logic                      ready;
  logic [ilp_pkg::CH_W-1:0]  ch;
  logic                      last;
  logic                      empty_token;

  modport source (output valid, ch, last, empty_token, input ready);
  modport sink   (input valid, ch, last, empty_token, output ready);
endinterface

[sv/ilp_out_if.sv]
// Result channel out of the parser: valid/ready plus status, value, radix.
// Depends on ilp_pkg for the value width.
interface ilp_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     status;
  logic signed [ilp_pkg::OUT_VALUE_W-1:0]   value;
  logic [1:0]                               radix;

  modport source (output valid, status, value, radix, input ready);
  modport sink   (input valid, status, value, radix, output ready);
endinterface

[sv/ilp_step.sv]
// One character of parse: next token state, accumulator update and the
// result the character would close with. Depends on ilp_pkg.
module ilp_step #(
  parameter int unsigned VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
  input  ilp_pkg::ctrl_t          ctrl_i,
  input  logic [VALUE_WIDTH-1:0]  acc_i,
  input  logic [ilp_pkg::CH_W-1:0] ch_i,
  input  logic                    last_i,
  input  logic                    empty_i,
  output ilp_pkg::ctrl_t          ctrl_o,
  output logic [VALUE_WIDTH-1:0]  acc_o,
  output logic                    done_o,
  output ilp_pkg::res_t           res_o
);
  import ilp_pkg::*;

  localparam int unsigned EXT_W = (VALUE_WIDTH > OUT_VALUE_W) ? VALUE_WIDTH : OUT_VALUE_W;

  ctrl_t                   ctrl_n;
  logic                    take;
  logic                    dig_ok;
  logic [3:0]              dig;
  logic [VALUE_WIDTH-1:0]  acc_scaled;
  logic [VALUE_WIDTH-1:0]  acc_n;
  logic [VALUE_WIDTH-1:0]  mag;
  logic signed [EXT_W-1:0] ext;

  // digit decode against the radix in force after this character
  always_comb begin
    dig_ok = 1'b0;
    dig    = '0;
    if (ctrl_n.radix_sel == RADIX_OCT) begin
      if (ch_i inside {[8'h30:8'h37]}) begin
        dig_ok = 1'b1;
        dig    = ch_i[3:0];
      end
    end else if (ch_i inside {[8'h30:8'h39]}) begin
      dig_ok = 1'b1;
      dig    = ch_i[3:0];
    end else if (ctrl_n.radix_sel == RADIX_HEX &&
                 (ch_i inside {[8'h61:8'h66]} || ch_i inside {[8'h41:8'h46]})) begin
      dig_ok = 1'b1;
      dig    = ch_i[3:0] + 4'd9;
    end
  end

  // acc * radix as shifts and one add
  always_comb begin
    case (ctrl_n.radix_sel)
      RADIX_HEX: acc_scaled = acc_i << 4;
      RADIX_OCT: acc_scaled = acc_i << 3;
      default:   acc_scaled = (acc_i << 3) + (acc_i << 1);
    endcase
  end

  always_comb begin
    ctrl_n = ctrl_i;
    take   = 1'b0;
    if (!ctrl_i.failed) begin
      case (ctrl_i.phase)
        PH_START: begin
          if (ch_i == CH_MINUS) begin
            ctrl_n.negative = 1'b1;
            ctrl_n.phase    = PH_SIGN;
          end else if (ch_i == CH_ZERO) begin
            ctrl_n.phase = PH_ZERO;
          end else begin
            take = 1'b1;
          end
        end
        PH_SIGN: begin
          if (ch_i == CH_ZERO) ctrl_n.phase = PH_ZERO;
          else                 take = 1'b1;
        end
        PH_ZERO: begin
          if (ch_i == CH_X) begin
            ctrl_n.radix_sel = RADIX_HEX;
            ctrl_n.phase     = PH_DIGITS;
          end else if (ch_i inside {[8'h30:8'h39]}) begin
            ctrl_n.radix_sel = RADIX_OCT;
            take             = 1'b1;
          end else begin
            ctrl_n.failed = 1'b1;
          end
        end
        default: take = 1'b1;
      endcase
    end
  end

  always_comb begin
    ctrl_o = ctrl_n;
    acc_n  = acc_i;
    if (take) begin
      ctrl_o.phase = PH_DIGITS;
      if (dig_ok) acc_n = acc_scaled + VALUE_WIDTH'(dig);
      else        ctrl_o.failed = 1'b1;
    end
  end

  assign acc_o  = acc_n;
  assign done_o = last_i | empty_i;

  // wrap, negate, sign-extend from VALUE_WIDTH, keep the low 32 bits
  assign mag = ctrl_n.negative ? (~acc_n + 1'b1) : acc_n;
  assign ext = EXT_W'(signed'(mag));

  always_comb begin
    if (empty_i || ctrl_o.failed) begin
      res_o.status = STATUS_ERR;
      res_o.value  = '0;
      res_o.radix  = RADIX_DEC;
    end else begin
      res_o.status = STATUS_OK;
      res_o.value  = ext[OUT_VALUE_W-1:0];
      res_o.radix  = ctrl_o.radix_sel;
    end
  end

endmodule

[sv/integer_literal_parser.sv]
// Integer literal parser, top level. Depends on ilp_pkg, ilp_in_if,
// ilp_out_if and ilp_step.
//
// A token arrives one character per transfer on in_i, the final one flagged
// by last; a transfer with empty_token set stands for a zero-length token.
// One result transfer on out_o closes each token: status (0 integer, 1 not
// an integer literal), the value wrapped to VALUE_WIDTH bits, negated when a
// leading minus was seen and sign-extended into 32 bits, and the radix
// (0 decimal, 1 octal after a leading 0 and digit, 2 hex after "0x").
// The block takes one character per cycle unless the input stalls: a
// character waits in the input register, and the accumulator loop
// (shift-add of the radix plus the digit) updates as it leaves, so
// characters stream with no gaps. A final character passes through the
// input register and then the result register, which decouples the
// sides: characters keep flowing while a result waits, and input stalls
// only when a closing character meets a result still not taken.
module integer_literal_parser #(
  parameter int unsigned VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ilp_in_if.sink        in_i,
  ilp_out_if.source     out_o
);
  import ilp_pkg::*;

  // input register
  logic               s1_valid_q;
  logic [CH_W-1:0]    s1_ch_q;
  logic               s1_last_q;
  logic               s1_empty_q;

  // token state
  ctrl_t                  ctrl_q;
  logic [VALUE_WIDTH-1:0] acc_q;

  // result register
  logic out_valid_q;
  res_t res_q;

  ctrl_t                  ctrl_step;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic                   done;
  res_t                   res_step;

  logic out_free;
  logic s1_adv;

  ilp_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .ctrl_i  (ctrl_q),
    .acc_i   (acc_q),
    .ch_i    (s1_ch_q),
    .last_i  (s1_last_q),
    .empty_i (s1_empty_q),
    .ctrl_o  (ctrl_step),
    .acc_o   (acc_step),
    .done_o  (done),
    .res_o   (res_step)
  );

  // A character without a result never waits on the output side.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!done || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_ch_q    <= in_i.ch;
      s1_last_q  <= in_i.last;
      s1_empty_q <= in_i.empty_token;
    end
  end

  // token state returns to its reset values after every result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= CTRL_RESET;
      acc_q  <= '0;
    end else if (s1_adv) begin
      if (done) begin
        ctrl_q <= CTRL_RESET;
        acc_q  <= '0;
      end else begin
        ctrl_q <= ctrl_step;
        acc_q  <= acc_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && done) begin
      res_q <= res_step;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = res_q.status;
  assign out_o.value  = res_q.value;
  assign out_o.radix  = res_q.radix;

endmodule
